/* src/tplm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_pkg
// Shared types and constants of the three-phase line monitor.
// ----------------------------------------------------------------------------
package tplm_pkg;

   localparam logic [2:0] REG_VOLTAGE_OFFSETS = 3'd0;
   localparam logic [2:0] REG_CURRENT_OFFSETS = 3'd1;
   localparam logic [2:0] REG_LOST_THRESHOLD  = 3'd2;
   localparam logic [2:0] REG_UNDER_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_OVER_THRESHOLD  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_LOST  = 2'd1;
   localparam logic [1:0] STATUS_UNDER = 2'd2;
   localparam logic [1:0] STATUS_OVER  = 2'd3;

   localparam logic [1:0] PHASE_NONE = 2'd3;

   localparam logic [15:0] LOST_RESET  = 16'd500;
   localparam logic [15:0] UNDER_RESET = 16'd1980;
   localparam logic [15:0] OVER_RESET  = 16'd2420;

   localparam logic [22:0] APPARENT_MAX = 23'd6553500;
   localparam logic [16:0] CURRENT_MAX  = 17'd131071;
   // ceil(2^37 / 125): divide by 1000 as (x >> 3) * MILLI_RECIP >> 37
   localparam logic [30:0] MILLI_RECIP  = 31'd1099511628;
   localparam logic [13:0] UNB_SCALE    = 14'd10000;
   localparam logic [17:0] UNB_MIN_SUM  = 18'd30;

   // one classified reading on its way from front to back
   typedef struct packed {
      logic [1:0]  phase;
      logic        valid;
      logic [1:0]  status;
      logic [15:0] vc;
      logic [16:0] ic;
      logic [17:0] ap;
      logic [6:0]  pf;
      logic [9:0]  freq;
      logic [23:0] energy;
      logic [32:0] prod;
      logic [17:0] sum;
      logic [17:0] maxdev;
      logic        unb_en;
   } entry_type;

endpackage

/* src/tplm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_front
// Holds configuration and per-phase state, calibrates and classifies readings.
// ----------------------------------------------------------------------------
module tplm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [47:0]           csr_write_data,
   input  logic                  take,
   input  logic [1:0]            phase_index,
   input  logic [15:0]           voltage_raw,
   input  logic [16:0]           current_raw,
   input  logic [17:0]           active_power_raw,
   input  logic [6:0]            power_factor_raw,
   input  logic [9:0]            frequency_raw,
   input  logic [23:0]           energy_raw,
   input  logic [5:0]            valid_mask,
   output tplm_pkg::entry_type   entry
);

   logic [47:0] voff_ff, ioff_ff;
   logic [15:0] lost_ff, under_ff, over_ff;
   logic [15:0] sv_ff [3];
   logic        sval_ff [3];
   logic [23:0] se_ff [3];
   logic [15:0] sv_in [3];
   logic        sval_in [3];
   logic [23:0] se_in [3];

   logic               valid, phase_ok;
   logic signed [15:0] voff, ioff;
   logic signed [17:0] vsum;
   logic signed [18:0] isum;
   logic [15:0]        vc;
   logic [16:0]        ic;
   logic [23:0]        en;
   logic [1:0]         status;
   logic [17:0]        sum, maxdev, t, dev;

   always_ff @(posedge clock) begin
      if (reset) begin
         voff_ff  <= '0;
         ioff_ff  <= '0;
         lost_ff  <= tplm_pkg::LOST_RESET;
         under_ff <= tplm_pkg::UNDER_RESET;
         over_ff  <= tplm_pkg::OVER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tplm_pkg::REG_VOLTAGE_OFFSETS: voff_ff  <= csr_write_data;
            tplm_pkg::REG_CURRENT_OFFSETS: ioff_ff  <= csr_write_data;
            tplm_pkg::REG_LOST_THRESHOLD:  lost_ff  <= csr_write_data[15:0];
            tplm_pkg::REG_UNDER_THRESHOLD: under_ff <= csr_write_data[15:0];
            tplm_pkg::REG_OVER_THRESHOLD:  over_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      valid    = (valid_mask[1:0] == 2'b11);
      phase_ok = (phase_index != tplm_pkg::PHASE_NONE);
      case (phase_index)
         2'd0: begin voff = voff_ff[15:0];  ioff = ioff_ff[15:0];  end
         2'd1: begin voff = voff_ff[31:16]; ioff = ioff_ff[31:16]; end
         2'd2: begin voff = voff_ff[47:32]; ioff = ioff_ff[47:32]; end
         default: begin voff = '0; ioff = '0; end
      endcase
      vsum = $signed({2'b00, voltage_raw}) + 18'(voff);
      isum = $signed({2'b00, current_raw}) + 19'(ioff);
      vc = 16'd0;
      ic = 17'd0;
      if (valid) begin
         if (vsum < 0) vc = 16'd0;
         else if (vsum > 18'sd65535) vc = 16'hFFFF;
         else vc = vsum[15:0];
         if (isum < 0) ic = 17'd0;
         else if (isum > 19'sd131071) ic = tplm_pkg::CURRENT_MAX;
         else ic = isum[16:0];
      end
      if (!valid) status = tplm_pkg::STATUS_LOST;
      else if (vc < lost_ff) status = tplm_pkg::STATUS_LOST;
      else if (vc < under_ff) status = tplm_pkg::STATUS_UNDER;
      else if (vc > over_ff) status = tplm_pkg::STATUS_OVER;
      else status = tplm_pkg::STATUS_OK;
      // a lost phase keeps the energy stored for it
      if (valid) en = valid_mask[5] ? energy_raw : 24'd0;
      else if (phase_ok) en = se_ff[phase_index];
      else en = 24'd0;
      for (int k = 0; k < 3; k++) begin
         sv_in[k]   = sv_ff[k];
         sval_in[k] = sval_ff[k];
         se_in[k]   = se_ff[k];
      end
      if (take && phase_ok) begin
         sv_in[phase_index]   = vc;
         sval_in[phase_index] = valid;
         se_in[phase_index]   = en;
      end
      // unbalance inputs from the state this item leaves behind
      sum = 18'(sv_in[0]) + 18'(sv_in[1]) + 18'(sv_in[2]);
      maxdev = '0;
      for (int k = 0; k < 3; k++) begin
         t   = (18'(sv_in[k]) << 1) + 18'(sv_in[k]);
         dev = (t > sum) ? t - sum : sum - t;
         if (dev > maxdev) maxdev = dev;
      end
      entry.phase  = phase_index;
      entry.valid  = valid;
      entry.status = status;
      entry.vc     = vc;
      entry.ic     = ic;
      entry.ap     = (valid && valid_mask[2]) ? active_power_raw : 18'd0;
      entry.pf     = (valid && valid_mask[3]) ? power_factor_raw : 7'd0;
      entry.freq   = (valid && valid_mask[4]) ? frequency_raw : 10'd0;
      entry.energy = en;
      entry.prod   = valid ? 33'(voltage_raw) * 33'(current_raw) : 33'd0;
      entry.sum    = sum;
      entry.maxdev = maxdev;
      entry.unb_en = sval_in[0] && sval_in[1] && sval_in[2] && (sum >= tplm_pkg::UNB_MIN_SUM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            sv_ff[k]   <= '0;
            sval_ff[k] <= 1'b0;
            se_ff[k]   <= '0;
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            sv_ff[k]   <= sv_in[k];
            sval_ff[k] <= sval_in[k];
            se_ff[k]   <= se_in[k];
         end
      end
   end

endmodule

/* src/tplm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_queue
// Short first-in first-out queue of classified readings.
// ----------------------------------------------------------------------------
module tplm_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tplm_pkg::entry_type push_data,
   input  logic                pop,
   output tplm_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tplm_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

/* src/tplm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_back
// Serial divide, multiply and square root; holds the result register.
// ----------------------------------------------------------------------------
module tplm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  tplm_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_phase_out,
   output logic                rsp_phase_valid,
   output logic [1:0]          rsp_line_status,
   output logic [15:0]         rsp_voltage_cal,
   output logic [16:0]         rsp_current_cal,
   output logic [17:0]         rsp_active_power,
   output logic [22:0]         rsp_apparent_power,
   output logic [22:0]         rsp_reactive_power,
   output logic [6:0]          rsp_power_factor,
   output logic [9:0]          rsp_frequency,
   output logic [23:0]         rsp_energy,
   output logic [14:0]         rsp_unbalance
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]  st_ff;
   logic [5:0]  cnt_ff;
   tplm_pkg::entry_type ent_ff;
   logic [32:0] q1_ff, q2_ff;
   logic [17:0] r2_ff;
   logic [22:0] s_ff;
   logic [14:0] unb_ff;
   logic [46:0] a_ff, acc_ff;
   logic [23:0] b_ff;
   logic [45:0] x_ff, res_ff, bit_ff;
   logic        rsp_valid_ff;

   logic [60:0] q1_mul;
   logic [18:0] r2n;
   logic [22:0] s_sat;
   logic [45:0] trial;

   assign pop       = (st_ff == ST_IDLE) && !empty;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      q1_mul = 61'(q1_ff[32:3]) * 61'(tplm_pkg::MILLI_RECIP);
      r2n    = {r2_ff, q2_ff[32]};
      s_sat  = (q1_ff > 33'(tplm_pkg::APPARENT_MAX)) ? tplm_pkg::APPARENT_MAX : q1_ff[22:0];
      trial  = res_ff + bit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: if (!empty) begin
               st_ff  <= ST_DIV;
               cnt_ff <= '0;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd32) st_ff <= ST_PREP;
            end
            ST_PREP: begin
               st_ff  <= ST_MUL;
               cnt_ff <= '0;
            end
            ST_MUL: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd23) begin
                  st_ff  <= ST_SQRT;
                  cnt_ff <= '0;
               end
            end
            ST_SQRT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'd22) st_ff <= ST_DONE;
            end
            ST_DONE: if (!rsp_valid_ff) begin
               st_ff        <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            ent_ff <= head;
            q1_ff  <= head.prod;
            q2_ff  <= 33'(head.maxdev * 32'(tplm_pkg::UNB_SCALE));
            r2_ff  <= '0;
         end
         ST_DIV: begin
            // apparent power: product over 1000 by reciprocal, once
            if (cnt_ff == 6'd0) q1_ff <= 33'(q1_mul[60:37]);
            // restoring step on the unbalance quotient
            if (r2n >= {1'b0, ent_ff.sum}) begin
               r2_ff <= 18'(r2n - {1'b0, ent_ff.sum});
               q2_ff <= {q2_ff[31:0], 1'b1};
            end else begin
               r2_ff <= r2n[17:0];
               q2_ff <= {q2_ff[31:0], 1'b0};
            end
         end
         ST_PREP: begin
            s_ff   <= s_sat;
            unb_ff <= ent_ff.unb_en ? q2_ff[14:0] : 15'd0;
            // S*S - P*P as (S-P)*(S+P), zero when P exceeds S
            a_ff   <= (s_sat >= 23'(ent_ff.ap)) ? 47'(s_sat - 23'(ent_ff.ap)) : 47'd0;
            b_ff   <= 24'(s_sat) + 24'(ent_ff.ap);
            acc_ff <= '0;
         end
         ST_MUL: begin
            if (b_ff[0]) acc_ff <= acc_ff + a_ff;
            a_ff <= a_ff << 1;
            b_ff <= b_ff >> 1;
            if (cnt_ff == 6'd23) begin
               x_ff   <= (b_ff[0]) ? 46'(acc_ff + a_ff) : acc_ff[45:0];
               res_ff <= '0;
               bit_ff <= 46'd1 << 44;
            end
         end
         ST_SQRT: begin
            if (x_ff >= trial) begin
               x_ff   <= x_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_DONE: if (!rsp_valid_ff) begin
            rsp_phase_out      <= ent_ff.phase;
            rsp_phase_valid    <= ent_ff.valid;
            rsp_line_status    <= ent_ff.status;
            rsp_voltage_cal    <= ent_ff.vc;
            rsp_current_cal    <= ent_ff.ic;
            rsp_active_power   <= ent_ff.ap;
            rsp_apparent_power <= s_ff;
            rsp_reactive_power <= res_ff[22:0];
            rsp_power_factor   <= ent_ff.pf;
            rsp_frequency      <= ent_ff.freq;
            rsp_energy         <= ent_ff.energy;
            rsp_unbalance      <= unb_ff;
         end
         default: ;
      endcase
   end

endmodule

/* src/three_phase_line_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_line_monitor
// Calibrates per-phase meter readings, derives power figures, line status
// and NEMA voltage unbalance.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_stall   one phase reading
//  rsp_      out        rsp_valid / rsp_stall   one result per reading
//  csr_      in         csr_write_enable        register index and data
//
//  A reading is taken the cycle it arrives if the queue has room; the front
//  calibrates it and updates the phase state at once.
//  The back takes one reading at a time and works it through 33 steps of the
//  restoring divider for the unbalance, 24 of the shift-add multiplier, 23 of the
//  square root, plus a pop, a preparation and a result state.
//  Reset is synchronous; it restores register defaults and clears state.
//  A waiting result stalls only the back; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module three_phase_line_monitor #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_phase_index,
   input  logic [15:0] req_voltage_raw,
   input  logic [16:0] req_current_raw,
   input  logic [17:0] req_active_power_raw,
   input  logic [6:0]  req_power_factor_raw,
   input  logic [9:0]  req_frequency_raw,
   input  logic [23:0] req_energy_raw,
   input  logic [5:0]  req_valid_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_phase_out,
   output logic        rsp_phase_valid,
   output logic [1:0]  rsp_line_status,
   output logic [15:0] rsp_voltage_cal,
   output logic [16:0] rsp_current_cal,
   output logic [17:0] rsp_active_power,
   output logic [22:0] rsp_apparent_power,
   output logic [22:0] rsp_reactive_power,
   output logic [6:0]  rsp_power_factor,
   output logic [9:0]  rsp_frequency,
   output logic [23:0] rsp_energy,
   output logic [14:0] rsp_unbalance
);

   tplm_pkg::entry_type front_entry, queue_head;
   logic take, full, empty, pop;

   // hold the requester off while the queue is full
   assign req_stall = full;
   assign take      = req_valid && !full;

   tplm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .phase_index      (req_phase_index),
      .voltage_raw      (req_voltage_raw),
      .current_raw      (req_current_raw),
      .active_power_raw (req_active_power_raw),
      .power_factor_raw (req_power_factor_raw),
      .frequency_raw    (req_frequency_raw),
      .energy_raw       (req_energy_raw),
      .valid_mask       (req_valid_mask),
      .entry            (front_entry)
   );

   tplm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (front_entry),
      .pop       (pop),
      .head      (queue_head),
      .full      (full),
      .empty     (empty)
   );

   tplm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (queue_head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_out      (rsp_phase_out),
      .rsp_phase_valid    (rsp_phase_valid),
      .rsp_line_status    (rsp_line_status),
      .rsp_voltage_cal    (rsp_voltage_cal),
      .rsp_current_cal    (rsp_current_cal),
      .rsp_active_power   (rsp_active_power),
      .rsp_apparent_power (rsp_apparent_power),
      .rsp_reactive_power (rsp_reactive_power),
      .rsp_power_factor   (rsp_power_factor),
      .rsp_frequency      (rsp_frequency),
      .rsp_energy         (rsp_energy),
      .rsp_unbalance      (rsp_unbalance)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line monitor testbench
// Drives phase readings and register writes into the three-phase line
// monitor, predicts each result in a scoreboard that tracks the per-phase
// voltage, validity and energy, and compares every field of every result.
// ----------------------------------------------------------------------------
module tb_top;

   // one phase reading as it enters the block
   typedef struct {
      logic [1:0]  phase;
      logic [15:0] volt;
      logic [16:0] curr;
      logic [17:0] power;
      logic [6:0]  pf;
      logic [9:0]  freq;
      logic [23:0] energy;
      logic [5:0]  mask;
   } reading_type;

   // one result as it leaves the block
   typedef struct {
      logic [1:0]  phase;
      logic        valid;
      logic [1:0]  status;
      logic [15:0] vcal;
      logic [16:0] ical;
      logic [17:0] active;
      logic [22:0] apparent;
      logic [22:0] reactive;
      logic [6:0]  pf;
      logic [9:0]  freq;
      logic [23:0] energy;
      logic [14:0] unbalance;
   } summary_type;

   int error_count = 0;

   // print one line per mismatch and count it
   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard: holds the monitor state and the queue of expected summaries
   // ------------------------------------------------------------------------
   class line_scoreboard;
      logic [47:0] volt_offsets, curr_offsets;
      logic [15:0] lost_th, under_th, over_th;
      logic [15:0] held_volt [3];
      bit          held_valid [3];
      logic [23:0] held_energy [3];
      summary_type pending [$];
      int          checked;

      function void clear();
         volt_offsets = 0; curr_offsets = 0;
         lost_th = tplm_pkg::LOST_RESET;
         under_th = tplm_pkg::UNDER_RESET;
         over_th = tplm_pkg::OVER_RESET;
         for (int k = 0; k < 3; k++) begin
            held_volt[k] = 0; held_valid[k] = 0; held_energy[k] = 0;
         end
         pending.delete();
         checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [47:0] val);
         case (idx)
            tplm_pkg::REG_VOLTAGE_OFFSETS: volt_offsets = val;
            tplm_pkg::REG_CURRENT_OFFSETS: curr_offsets = val;
            tplm_pkg::REG_LOST_THRESHOLD:  lost_th = val[15:0];
            tplm_pkg::REG_UNDER_THRESHOLD: under_th = val[15:0];
            tplm_pkg::REG_OVER_THRESHOLD:  over_th = val[15:0];
            default: ;
         endcase
      endfunction

      function longint offset_for(logic [47:0] packed_offs, logic [1:0] ph);
         if (ph == tplm_pkg::PHASE_NONE) return 0;
         return longint'($signed(packed_offs[16*ph +: 16]));
      endfunction

      function longint root_floor(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint unbalance_now();
         longint total, dev, worst;
         if (!(held_valid[0] && held_valid[1] && held_valid[2])) return 0;
         total = held_volt[0] + held_volt[1] + held_volt[2];
         if (total < 30) return 0;
         worst = 0;
         for (int k = 0; k < 3; k++) begin
            dev = 3 * held_volt[k] - total;
            if (dev < 0) dev = -dev;
            if (dev > worst) worst = dev;
         end
         return worst * 10000 / total;
      endfunction

      // note an accepted reading: update state and queue its summary
      function void note_reading(reading_type r);
         summary_type s;
         longint vx, ix, app;
         s = '{default: 0};
         s.phase = r.phase;
         s.status = tplm_pkg::STATUS_LOST;
         if (r.mask[1:0] == 2'b11) begin
            s.valid = 1;
            vx = longint'(r.volt) + offset_for(volt_offsets, r.phase);
            ix = longint'(r.curr) + offset_for(curr_offsets, r.phase);
            s.vcal = vx < 0 ? 0 : (vx > 65535 ? 65535 : vx);
            s.ical = ix < 0 ? 0 : (ix > 131071 ? 131071 : ix);
            s.active = r.mask[2] ? r.power : 0;
            s.pf = r.mask[3] ? r.pf : 0;
            s.freq = r.mask[4] ? r.freq : 0;
            s.energy = r.mask[5] ? r.energy : 0;
            app = longint'(r.volt) * longint'(r.curr) / 1000;
            if (app > 6553500) app = 6553500;
            s.apparent = app;
            if (app >= s.active)
               s.reactive = root_floor(app * app - longint'(s.active) * s.active);
            if (s.vcal < lost_th) s.status = tplm_pkg::STATUS_LOST;
            else if (s.vcal < under_th) s.status = tplm_pkg::STATUS_UNDER;
            else if (s.vcal > over_th) s.status = tplm_pkg::STATUS_OVER;
            else s.status = tplm_pkg::STATUS_OK;
         end else if (r.phase != tplm_pkg::PHASE_NONE) begin
            s.energy = held_energy[r.phase];
         end
         if (r.phase != tplm_pkg::PHASE_NONE) begin
            held_volt[r.phase] = s.vcal;
            held_valid[r.phase] = s.valid;
            held_energy[r.phase] = s.energy;
         end
         s.unbalance = unbalance_now();
         pending.push_back(s);
      endfunction

      // compare one result with the oldest expectation
      task check_result(summary_type g);
         summary_type w;
         if (pending.size() == 0) begin
            report("unexpected result, phase", g.phase, -1);
            return;
         end
         w = pending.pop_front();
         checked++;
         if (g.phase !== w.phase) report("phase_out", g.phase, w.phase);
         if (g.valid !== w.valid) report("phase_valid", g.valid, w.valid);
         if (g.status !== w.status) report("line_status", g.status, w.status);
         if (g.vcal !== w.vcal) report("voltage_cal", g.vcal, w.vcal);
         if (g.ical !== w.ical) report("current_cal", g.ical, w.ical);
         if (g.active !== w.active) report("active_power", g.active, w.active);
         if (g.apparent !== w.apparent) report("apparent_power", g.apparent, w.apparent);
         if (g.reactive !== w.reactive) report("reactive_power", g.reactive, w.reactive);
         if (g.pf !== w.pf) report("power_factor", g.pf, w.pf);
         if (g.freq !== w.freq) report("frequency", g.freq, w.freq);
         if (g.energy !== w.energy) report("energy", g.energy, w.energy);
         if (g.unbalance !== w.unbalance) report("unbalance", g.unbalance, w.unbalance);
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, DUT and signals
   // ------------------------------------------------------------------------
   logic clock = 0;
   logic reset = 1;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic        csr_write_enable = 0;
   logic [2:0]  csr_index = 0;
   logic [47:0] csr_write_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_phase_index = 0;
   logic [15:0] req_voltage_raw = 0;
   logic [16:0] req_current_raw = 0;
   logic [17:0] req_active_power_raw = 0;
   logic [6:0]  req_power_factor_raw = 0;
   logic [9:0]  req_frequency_raw = 0;
   logic [23:0] req_energy_raw = 0;
   logic [5:0]  req_valid_mask = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_phase_out;
   logic        rsp_phase_valid;
   logic [1:0]  rsp_line_status;
   logic [15:0] rsp_voltage_cal;
   logic [16:0] rsp_current_cal;
   logic [17:0] rsp_active_power;
   logic [22:0] rsp_apparent_power;
   logic [22:0] rsp_reactive_power;
   logic [6:0]  rsp_power_factor;
   logic [9:0]  rsp_frequency;
   logic [23:0] rsp_energy;
   logic [14:0] rsp_unbalance;

   three_phase_line_monitor DUT (.*);

   line_scoreboard board = new();
   int sent = 0;
   bit sink_busy_phase = 0;   // selects random stalls or none on the result side

   // short gaps mostly, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // ------------------------------------------------------------------------
   // Driving tasks: inputs change on the falling edge
   // ------------------------------------------------------------------------
   task automatic write_csr(logic [2:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      board.write_reg(idx, val);
   endtask

   // present one reading and hold it until a transfer takes it
   task automatic send_reading(reading_type r, bit gap_ok);
      int g;
      g = gap_ok ? pick_gap() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_phase_index <= r.phase;
      req_voltage_raw <= r.volt;
      req_current_raw <= r.curr;
      req_active_power_raw <= r.power;
      req_power_factor_raw <= r.pf;
      req_frequency_raw <= r.freq;
      req_energy_raw <= r.energy;
      req_valid_mask <= r.mask;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      board.note_reading(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic idle_source();
      req_valid <= 0;
   endtask

   // wait until every expected result is in, then let the back settle
   task automatic drain();
      idle_source();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   function automatic reading_type build(logic [1:0] ph, logic [15:0] v, logic [16:0] i,
                                         logic [17:0] p, logic [5:0] m);
      reading_type r;
      r.phase = ph; r.volt = v; r.curr = i; r.power = p;
      r.pf = $urandom_range(0, 127);
      r.freq = $urandom_range(0, 1023);
      r.energy = $urandom;
      r.mask = m;
      return r;
   endfunction

   // mostly realistic readings around mains voltage, some anything goes
   function automatic reading_type random_reading();
      reading_type r;
      int kind;
      kind = $urandom_range(0, 99);
      r = build($urandom_range(0, 2), 0, 0, 0, 6'h3f);
      if (kind < 70) begin
         r.volt = $urandom_range(1800, 2600);
         r.curr = $urandom_range(0, 100000);
         r.power = $urandom_range(0, 230000);
         r.pf = $urandom_range(0, 100);
         r.freq = $urandom_range(450, 650);
         r.energy = $urandom_range(0, 9999999);
         if ($urandom_range(0, 9) == 0) r.mask = $urandom_range(0, 63);
      end else begin
         r.phase = $urandom_range(0, 3);
         r.volt = $urandom;
         r.curr = $urandom;
         r.power = $urandom;
         r.mask = $urandom_range(0, 63);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: sample on the rising edge, stall changes on the falling one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_phase_out, rsp_phase_valid, rsp_line_status,
            rsp_voltage_cal, rsp_current_cal, rsp_active_power, rsp_apparent_power,
            rsp_reactive_power, rsp_power_factor, rsp_frequency, rsp_energy,
            rsp_unbalance});
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (sink_busy_phase) begin
            g = pick_gap();
            if (g > 0) begin
               rsp_stall <= 1;
               repeat (g) @(negedge clock);
            end
         end
         rsp_stall <= 0;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      reading_type r;
      board.clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset thresholds, extremes and each special case
      send_reading(build(0, 2200, 10000, 20000, 6'h3f), 0);
      send_reading(build(1, 2300, 20000, 0, 6'h3f), 0);
      send_reading(build(2, 2100, 5000, 230000, 6'h3f), 0); // active above apparent
      send_reading(build(0, 16'hffff, 17'h1ffff, 18'h3ffff, 6'h3f), 0); // saturations
      send_reading(build(1, 0, 0, 0, 6'h3f), 0);             // zero voltage, lost
      send_reading(build(1, 1000, 100, 0, 6'h3f), 0);        // under
      send_reading(build(1, 3000, 100, 0, 6'h3f), 0);        // over
      send_reading(build(2, 2200, 100, 50, 6'h02), 0);       // voltage flag clear
      send_reading(build(2, 2200, 100, 50, 6'h01), 0);       // current flag clear
      send_reading(build(2, 2200, 100, 50, 6'h03), 0);       // optional flags clear
      send_reading(build(3, 2200, 100, 50, 6'h3f), 0);       // phase index three
      send_reading(build(3, 2200, 100, 50, 6'h00), 0);       // phase three lost
      send_reading(build(0, 5, 1, 0, 6'h3f), 0);             // tiny voltages: sum below 30
      send_reading(build(1, 5, 1, 0, 6'h3f), 0);
      send_reading(build(2, 5, 1, 0, 6'h3f), 0);
      send_reading(build(2, 500, 1, 0, 6'h3f), 0);           // exactly at lost threshold
      send_reading(build(2, 2420, 1, 0, 6'h3f), 0);          // exactly at over threshold
      drain();

      // extreme offsets and thresholds
      write_csr(tplm_pkg::REG_VOLTAGE_OFFSETS, {16'h7fff, 16'h8000, 16'hffff});
      write_csr(tplm_pkg::REG_CURRENT_OFFSETS, {16'h8000, 16'h7fff, 16'h0001});
      write_csr(tplm_pkg::REG_LOST_THRESHOLD, 16'hffff);
      write_csr(tplm_pkg::REG_UNDER_THRESHOLD, 16'h0000);
      write_csr(tplm_pkg::REG_OVER_THRESHOLD, 16'h0000);
      for (int k = 0; k < 6; k++)
         send_reading(build(k % 3, 16'hffff * (k & 1), 17'h1ffff, 0, 6'h3f), 0);
      drain();
      write_csr(tplm_pkg::REG_LOST_THRESHOLD, 0);

      // random phases with differing settings and back-pressure
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(tplm_pkg::REG_VOLTAGE_OFFSETS,
                   ph == 4 ? 48'h0 : {$urandom, $urandom} & 48'h00ff_00ff_00ff);
         write_csr(tplm_pkg::REG_CURRENT_OFFSETS,
                   ph == 3 ? 48'hffff_ffff_ffff : {$urandom, $urandom});
         write_csr(tplm_pkg::REG_LOST_THRESHOLD, ph == 4 ? 16'hffff : $urandom_range(0, 1900));
         write_csr(tplm_pkg::REG_UNDER_THRESHOLD,
                   ph == 4 ? 16'hffff : $urandom_range(1900, 2200));
         write_csr(tplm_pkg::REG_OVER_THRESHOLD, ph == 4 ? 16'h0 : $urandom_range(2200, 2600));
         sink_busy_phase = ph % 2;
         for (int n = 0; n < 210; n++) begin
            r = random_reading();
            send_reading(r, ph != 2);
         end
         drain();
      end

      $display("Run covered %0d readings, %0d results checked, over seven register settings.",
               sent, board.checked);
      if (error_count == 0)
         $display("** three_phase_line_monitor: PASSED **");
      else
         $display("** three_phase_line_monitor: FAILED **");
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #40ms;
      $display("Timeout with %0d results outstanding", board.pending.size());
      $display("** three_phase_line_monitor: FAILED **");
      $finish;
   end

endmodule
